// ----- hw/rtl/rprd_pkg.sv -----
// ----------------------------------------------------------------------------
// rprd_pkg
// Shared types, verb codes and coordinate helpers for the relative path
// record decoder.
// ----------------------------------------------------------------------------
package rprd_pkg;

	// coordinate arithmetic width; results carry the low 32 bits
	localparam int COORD_WIDTH = 32;
	localparam int OUT_WIDTH   = 32;

	// element layout: verb byte then eight interleaved coordinate bytes
	localparam int          ELEM_BYTES = 9;
	localparam logic [3:0]  LAST_POS   = 4'(ELEM_BYTES - 1);

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// verb codes
	localparam logic [7:0] VERB_LINE        = 8'd2;
	localparam logic [7:0] VERB_LINE_CLOSE  = 8'd3;
	localparam logic [7:0] VERB_CURVE       = 8'd4;
	localparam logic [7:0] VERB_CURVE_CLOSE = 8'd5;
	localparam logic [7:0] VERB_MOVE        = 8'd6;

	typedef logic [COORD_WIDTH-1:0] coord_t;
	typedef logic [OUT_WIDTH-1:0]   ocoord_t;

	typedef enum logic [1:0] {
		KIND_MOVE  = 2'd0,
		KIND_LINE  = 2'd1,
		KIND_CURVE = 2'd2,
		KIND_DONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_MOVE  = 2'd0,
		OP_LINE  = 2'd1,
		OP_CURVE = 2'd2
	} op_t;

	// which curve point an element is
	typedef enum logic [1:0] {
		SLOT_FIRST  = 2'd0,
		SLOT_SECOND = 2'd1,
		SLOT_EMIT   = 2'd2
	} slot_t;

	// one queue word: work the back part does for one byte
	typedef struct packed {
		logic   clear;
		logic   has_elem;
		op_t    op;
		slot_t  slot;
		logic   closes;
		logic   has_done;
		logic   path_closed;
		coord_t dx;
		coord_t dy;
	} entry_t;

	// one result word
	typedef struct packed {
		kind_t   kind;
		ocoord_t p1_x;
		ocoord_t p1_y;
		ocoord_t p2_x;
		ocoord_t p2_y;
		ocoord_t p3_x;
		ocoord_t p3_y;
		logic    closes;
		logic    path_closed;
		logic    last;
	} result_t;

	// sign-extend or truncate a 32-bit field to coordinate width
	function automatic coord_t to_coord(input logic [31:0] v);
		return coord_t'($signed(v));
	endfunction

	// low bits of a coordinate for the result ports
	function automatic ocoord_t to_out(input coord_t c);
		return ocoord_t'(c);
	endfunction

endpackage

// ----- hw/rtl/rprd_front.sv -----
// ----------------------------------------------------------------------------
// rprd_front
// Assembles record bytes into elements, classifies verbs, tracks curve point
// count and the closed flag, and pushes work words to the queue.
// ----------------------------------------------------------------------------
module rprd_front import rprd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       record_start,
	input  logic       record_end,
	output logic       q_push,
	output entry_t     q_word
);

	logic [3:0]  pos_q;
	logic [7:0]  verb_hold_q;
	logic [31:0] x_asm_q;
	logic [31:0] y_asm_q;
	logic [1:0]  count_q;
	logic        closed_q;
	logic        pend_clear_q;

	logic [3:0]  pos0;
	logic [1:0]  count0;
	logic        closed0;
	logic        last_byte;
	logic        has_elem;
	op_t         op;
	logic        closes;
	logic [1:0]  count_next;
	logic        closed_next;

	// view the state after a record start has cleared it
	always_comb begin
		pos0      = record_start ? '0 : pos_q;
		count0    = record_start ? '0 : count_q;
		closed0   = record_start ? 1'b0 : closed_q;
		last_byte = (pos0 >= LAST_POS);
	end

	// classify the verb of a completed element
	always_comb begin
		has_elem   = 1'b0;
		op         = OP_MOVE;
		closes     = 1'b0;
		count_next = count0;
		if (last_byte) begin
			unique case (verb_hold_q) inside
				VERB_MOVE: begin
					has_elem = 1'b1;
					op       = OP_MOVE;
				end
				VERB_LINE, VERB_LINE_CLOSE: begin
					has_elem = 1'b1;
					op       = OP_LINE;
					closes   = (verb_hold_q == VERB_LINE_CLOSE);
				end
				VERB_CURVE, VERB_CURVE_CLOSE: begin
					has_elem = 1'b1;
					op       = OP_CURVE;
					if (slot_t'(count0) == SLOT_EMIT) begin
						closes     = (verb_hold_q == VERB_CURVE_CLOSE);
						count_next = '0;
					end else begin
						count_next = count0 + 2'd1;
					end
				end
				default: begin
					has_elem = 1'b0;
				end
			endcase
		end
		closed_next = closed0 | (has_elem & closes);
	end

	// build the queue word
	always_comb begin
		q_word.clear       = record_start | pend_clear_q;
		q_word.has_elem    = has_elem;
		q_word.op          = op;
		q_word.slot        = slot_t'(count0);
		q_word.closes      = closes;
		q_word.has_done    = record_end;
		q_word.path_closed = closed_next;
		q_word.dx          = to_coord(x_asm_q);
		q_word.dy          = to_coord({y_asm_q[23:0], data_byte});
		q_push             = accept & (has_elem | record_end);
	end

	// advance byte position and element state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			verb_hold_q  <= '0;
			x_asm_q      <= '0;
			y_asm_q      <= '0;
			count_q      <= '0;
			closed_q     <= 1'b0;
			pend_clear_q <= 1'b0;
		end else if (accept) begin
			if (pos0 == '0) begin
				verb_hold_q <= data_byte;
			end else if (pos0[0]) begin
				x_asm_q <= {x_asm_q[23:0], data_byte};
			end else begin
				y_asm_q <= {y_asm_q[23:0], data_byte};
			end
			pos_q    <= (last_byte || record_end) ? '0 : pos0 + 4'd1;
			count_q  <= count_next;
			closed_q <= closed_next;
			// hold a record start until a word carries it to the back
			if (q_push) begin
				pend_clear_q <= 1'b0;
			end else if (record_start) begin
				pend_clear_q <= 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/rprd_queue.sv -----
// ----------------------------------------------------------------------------
// rprd_queue
// Short first-in first-out queue of work words between front and back.
// ----------------------------------------------------------------------------
module rprd_queue import rprd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wdata,
	input  logic   pop,
	output entry_t rdata,
	output logic   valid,
	output logic   full
);

	entry_t            store_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;

	assign valid = (count_q != '0);
	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign rdata = store_q[rptr_q];

	// write the word
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wptr_q] <= wdata;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/rprd_back.sv -----
// ----------------------------------------------------------------------------
// rprd_back
// Carries out queued work: updates the current point, keeps curve control
// points, flips y and drives the result register.
// ----------------------------------------------------------------------------
module rprd_back import rprd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] page_height,
	input  logic        q_valid,
	input  entry_t      q_word,
	output logic        q_pop,
	input  logic        pop,
	output logic        out_valid,
	output result_t     out_word
);

	coord_t  cur_x_q;
	coord_t  cur_y_q;
	coord_t  cp_q [4];
	logic    phase_q;
	logic    out_valid_q;
	result_t out_word_q;

	logic    adv;
	logic    take;
	coord_t  base_x;
	coord_t  base_y;
	coord_t  new_x;
	coord_t  new_y;
	coord_t  height;
	logic    emit;
	logic    produce;
	result_t res;

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// work out the next point and the result word
	always_comb begin
		adv     = !out_valid_q || pop;
		take    = q_valid && adv;
		height  = to_coord(page_height);
		base_x  = q_word.clear ? '0 : cur_x_q;
		base_y  = q_word.clear ? '0 : cur_y_q;
		new_x   = (q_word.op == OP_MOVE) ? q_word.dx : base_x - q_word.dx;
		new_y   = (q_word.op == OP_MOVE) ? q_word.dy : base_y - q_word.dy;
		emit    = q_word.has_elem && (q_word.op != OP_CURVE || q_word.slot == SLOT_EMIT);
		produce = phase_q || emit || q_word.has_done;
		q_pop   = take && !(!phase_q && emit && q_word.has_done);

		res = '0;
		if (phase_q || !emit) begin
			res.kind        = KIND_DONE;
			res.path_closed = q_word.path_closed;
			res.last        = 1'b1;
		end else if (q_word.op == OP_CURVE) begin
			res.kind   = KIND_CURVE;
			res.p1_x   = to_out(cp_q[0]);
			res.p1_y   = to_out(height - cp_q[1]);
			res.p2_x   = to_out(cp_q[2]);
			res.p2_y   = to_out(height - cp_q[3]);
			res.p3_x   = to_out(new_x);
			res.p3_y   = to_out(height - new_y);
			res.closes = q_word.closes;
			res.last   = !q_word.has_done;
		end else begin
			res.kind   = (q_word.op == OP_MOVE) ? KIND_MOVE : KIND_LINE;
			res.p1_x   = to_out(new_x);
			res.p1_y   = to_out(height - new_y);
			res.closes = q_word.closes;
			res.last   = !q_word.has_done;
		end
	end

	// keep control points of a curve in progress
	always_ff @(posedge clk) begin
		if (take && !phase_q && q_word.has_elem && q_word.op == OP_CURVE) begin
			if (q_word.slot == SLOT_FIRST) begin
				cp_q[0] <= new_x;
				cp_q[1] <= new_y;
			end else if (q_word.slot == SLOT_SECOND) begin
				cp_q[2] <= new_x;
				cp_q[3] <= new_y;
			end
		end
	end

	// advance the current point and the done phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			phase_q <= 1'b0;
		end else if (take) begin
			if (!phase_q) begin
				if (q_word.has_elem) begin
					cur_x_q <= new_x;
					cur_y_q <= new_y;
				end else if (q_word.clear) begin
					cur_x_q <= '0;
					cur_y_q <= '0;
				end
				phase_q <= emit && q_word.has_done;
			end else begin
				phase_q <= 1'b0;
			end
		end
	end

	// hold the result until it is popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= take && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (take && produce) begin
			out_word_q <= res;
		end
	end

endmodule

// ----- hw/rtl/relative_path_record_decoder_core.sv -----
// ----------------------------------------------------------------------------
// relative_path_record_decoder_core
// Decodes path record bytes into move, line, cubic curve and done words.
//
//  channel   | handshake            | words
//  ----------+----------------------+---------------------------------------
//  input     | push / full          | data_byte, record_start, record_end
//  result    | empty / pop          | segment_kind, point1..3 x/y, flags
//  config    | page_height_we       | page_height (one register)
//
// One byte is taken per cycle while the four-word work queue has room.
// A byte that ends both a record and an element that yields a result
// gives two results, the element then the done word, and its queue word
// stays at the back part until both are out; other queued words give at
// most one result, and bytes that yield no word never reach it. Results are
// registered as the back part takes their word. The result register is held
// until popped; the back part stalls on it and the front stalls only when
// the queue is full.
// Reset clears all control state at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module relative_path_record_decoder_core import rprd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	input  logic               record_start,
	input  logic               record_end,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         segment_kind,
	output logic signed [31:0] point1_x,
	output logic signed [31:0] point1_y,
	output logic signed [31:0] point2_x,
	output logic signed [31:0] point2_y,
	output logic signed [31:0] point3_x,
	output logic signed [31:0] point3_y,
	output logic               closes_here,
	output logic               path_closed,
	output logic               last_of_run,
	input  logic               page_height_we,
	input  logic signed [31:0] page_height
);

	logic [31:0] page_height_q;
	logic        q_full;
	logic        q_push;
	entry_t      q_wdata;
	logic        q_pop;
	entry_t      q_rdata;
	logic        q_valid;
	logic        out_valid;
	result_t     out_word;
	logic        accept;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign empty  = !out_valid;

	// hold the page height register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_height_q <= '0;
		end else if (page_height_we) begin
			page_height_q <= page_height;
		end
	end

	rprd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (data_byte),
		.record_start (record_start),
		.record_end   (record_end),
		.q_push       (q_push),
		.q_word       (q_wdata)
	);

	rprd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.valid  (q_valid),
		.full   (q_full)
	);

	rprd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.page_height (page_height_q),
		.q_valid     (q_valid),
		.q_word      (q_rdata),
		.q_pop       (q_pop),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_word    (out_word)
	);

	// drive the result ports
	assign segment_kind = out_word.kind;
	assign point1_x     = out_word.p1_x;
	assign point1_y     = out_word.p1_y;
	assign point2_x     = out_word.p2_x;
	assign point2_y     = out_word.p2_y;
	assign point3_x     = out_word.p3_x;
	assign point3_y     = out_word.p3_y;
	assign closes_here  = out_word.closes;
	assign path_closed  = out_word.path_closed;
	assign last_of_run  = out_word.last;

endmodule
